// File: design/hlsa_pkg.sv
`default_nettype none
package hlsa_pkg;

    localparam int MAX_HOLES = 16;
    localparam int ADDR_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_HOLES);
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int SIZE_W    = ADDR_BITS + 1;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_NO_FIT  = 3'd1;
    localparam logic [2:0] ST_SKIPPED = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_RESET   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic [2:0] REG_TOTAL_ADDR = 3'd0;
    localparam logic [2:0] REG_FIT_ADDR   = 3'd4;

    localparam logic [15:0] TOTAL_RESET = 16'd1000;
    localparam logic [15:0] TOTAL_MIN   = 16'd10;

    // A hole may span the whole address space, so its size has one extra bit.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } hole_t;

    localparam int HOLE_W = $bits(hole_t);

    typedef struct packed {
        logic [15:0] total_size;
        logic        fit_policy;
    } cfg_t;

endpackage
`default_nettype wire

// File: design/hole_list_segment_allocator_top.sv
`default_nettype none
// Hole-list segment allocator.
// Requests enter on start/command/group_first/group_last/region_address/
// region_size and are taken when start is high and busy is low. Each request
// with a command of allocate, free or reset gives one result: done is high for
// exactly one cycle with seg_base, status and committed; the receiver
// cannot stall it. Command three is taken and dropped without a result.
// The hole table and its working copy each live in a 16-entry synchronous RAM
// that is read one entry at a time, so latency follows the table size: an
// allocate runs a search, with a group-start copy before it and a shift and a
// commit copy after it where needed; a free runs a position scan, a merge pass
// and a copy back; a reset rewrites the single initial hole. One request is
// worked on at a time. After reset the block writes the single initial hole
// while busy is high; total_size and fit_policy are written over the APB port
// (byte address 0 and 4), and a new total_size is used at the next reset
// request.
module hole_list_segment_allocator_top
    import hlsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic        group_first,
    input  wire logic        group_last,
    input  wire logic [15:0] region_address,
    input  wire logic [15:0] region_size,
    output logic             done,
    output logic [15:0]      seg_base,
    output logic [2:0]       status,
    output logic             committed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t cfg;

    hlsa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hlsa_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .group_first    (group_first),
        .group_last     (group_last),
        .region_address (region_address),
        .region_size    (region_size),
        .done           (done),
        .seg_base       (seg_base),
        .status         (status),
        .committed      (committed)
    );

endmodule
`default_nettype wire

// File: design/hlsa_ram.sv
`default_nettype none
module hlsa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/hlsa_cfg.sv
`default_nettype none
module hlsa_cfg
    import hlsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [15:0] total_reg;
    logic        fit_reg;
    logic        wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            fit_reg   <= 1'b0;
        end
        else if (wr)
        begin
            if (!paddr[2])
            begin
                total_reg <= (pwdata[15:0] < TOTAL_MIN) ? TOTAL_MIN : pwdata[15:0];
            end
            else
            begin
                fit_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (!paddr[2])
        begin
            prdata = {16'd0, total_reg};
        end
        else
        begin
            prdata = {31'd0, fit_reg};
        end
    end

    assign cfg.total_size = total_reg;
    assign cfg.fit_policy = fit_reg;

endmodule
`default_nettype wire

// File: design/hlsa_ctrl.sv
`default_nettype none
module hlsa_ctrl
    import hlsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  cfg_t                      cfg,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           command,
    input  wire logic                 group_first,
    input  wire logic                 group_last,
    input  wire logic [15:0]          region_address,
    input  wire logic [15:0]          region_size,
    output logic                      done,
    output logic [15:0]               seg_base,
    output logic [2:0]                status,
    output logic                      committed
);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RST   = 5'd2;
    localparam logic [4:0] S_CP_RD = 5'd3;
    localparam logic [4:0] S_CP_WR = 5'd4;
    localparam logic [4:0] S_A_CHK = 5'd5;
    localparam logic [4:0] S_A_RD  = 5'd6;
    localparam logic [4:0] S_A_EX  = 5'd7;
    localparam logic [4:0] S_A_DEC = 5'd8;
    localparam logic [4:0] S_SH_RD = 5'd9;
    localparam logic [4:0] S_SH_WR = 5'd10;
    localparam logic [4:0] S_A_FIN = 5'd11;
    localparam logic [4:0] S_P_RD  = 5'd12;
    localparam logic [4:0] S_P_EX  = 5'd13;
    localparam logic [4:0] S_M_RD  = 5'd14;
    localparam logic [4:0] S_M_EX  = 5'd15;
    localparam logic [4:0] S_M_END = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic [ADDR_BITS+1:0] LIMIT = (ADDR_BITS+2)'(1) << ADDR_BITS;

    logic [4:0]           state_reg, state_next;
    logic [CNT_W-1:0]     hc_reg, hc_next, wc_reg, wc_next;
    logic                 gf_reg, gf_next;
    logic [CNT_W-1:0]     i_reg, i_next, pos_reg, pos_next, n_reg, n_next;
    logic [CNT_W-1:0]     pick_reg, pick_next, cpn_reg, cpn_next;
    logic                 found_reg, found_next, ins_reg, ins_next;
    logic                 have_reg, have_next, ovf_reg, ovf_next;
    logic                 h2w_reg, h2w_next;
    logic [4:0]           ret_reg, ret_next;
    hole_t                cur_reg, cur_next, pe_reg, pe_next;
    logic [SIZE_W-1:0]    best_reg, best_next, sz_reg, sz_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 last_reg, last_next;
    logic [15:0]          base_reg, base_next;
    logic [2:0]           status_reg, status_next;
    logic                 comm_reg, comm_next, done_reg, done_next;

    logic                 h_we, w_we;
    logic [IDX_W-1:0]     h_waddr, w_waddr, rd_addr;
    hole_t                h_wdata, w_wdata, h_rdata, w_rdata;

    hlsa_ram #(.DEPTH(MAX_HOLES), .WIDTH(HOLE_W)) u_hole_mem (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (rd_addr),
        .rdata (h_rdata)
    );

    hlsa_ram #(.DEPTH(MAX_HOLES), .WIDTH(HOLE_W)) u_work_mem (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (rd_addr),
        .rdata (w_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            hc_reg    <= '0;
            wc_reg    <= '0;
            gf_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hc_reg    <= hc_next;
            wc_reg    <= wc_next;
            gf_reg    <= gf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        pick_reg   <= pick_next;
        cpn_reg    <= cpn_next;
        found_reg  <= found_next;
        ins_reg    <= ins_next;
        have_reg   <= have_next;
        ovf_reg    <= ovf_next;
        h2w_reg    <= h2w_next;
        ret_reg    <= ret_next;
        cur_reg    <= cur_next;
        pe_reg     <= pe_next;
        best_reg   <= best_next;
        sz_reg     <= sz_next;
        addr_reg   <= addr_next;
        last_reg   <= last_next;
        base_reg   <= base_next;
        status_reg <= status_next;
        comm_reg   <= comm_next;
    end

    always_comb
    begin
        hole_t                e;
        hole_t                fresh;
        logic                 mrg;
        logic                 emit;
        logic [SIZE_W-1:0]    cend;
        logic [SIZE_W-1:0]    diff;
        logic [ADDR_BITS+1:0] sum;

        state_next  = state_reg;
        hc_next     = hc_reg;
        wc_next     = wc_reg;
        gf_next     = gf_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        pick_next   = pick_reg;
        cpn_next    = cpn_reg;
        found_next  = found_reg;
        ins_next    = ins_reg;
        have_next   = have_reg;
        ovf_next    = ovf_reg;
        h2w_next    = h2w_reg;
        ret_next    = ret_reg;
        cur_next    = cur_reg;
        pe_next     = pe_reg;
        best_next   = best_reg;
        sz_next     = sz_reg;
        addr_next   = addr_reg;
        last_next   = last_reg;
        base_next   = base_reg;
        status_next = status_reg;
        comm_next   = comm_reg;
        done_next   = 1'b0;
        h_we        = 1'b0;
        w_we        = 1'b0;
        h_waddr     = '0;
        w_waddr     = '0;
        h_wdata     = '0;
        w_wdata     = '0;
        rd_addr     = i_reg[IDX_W-1:0];
        mrg         = 1'b0;
        emit        = 1'b0;
        e           = '0;
        fresh.start = '0;
        fresh.size  = {1'b0, cfg.total_size};
        diff        = w_rdata.size - sz_reg;
        sum         = {2'b00, region_address} + {2'b00, region_size};

        case (state_reg)
            S_INIT, S_RST:
            begin
                h_we    = 1'b1;
                w_we    = 1'b1;
                h_wdata = fresh;
                w_wdata = fresh;
                hc_next = CNT_W'(1);
                wc_next = CNT_W'(1);
                gf_next = 1'b0;
                if (state_reg == S_RST)
                begin
                    status_next = ST_RESET;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    last_next  = group_last;
                    addr_next  = region_address;
                    base_next  = '0;
                    comm_next  = 1'b0;
                    i_next     = '0;
                    case (command)
                        CMD_ALLOC:
                        begin
                            sz_next = {1'b0, region_size};
                            if (group_first)
                            begin
                                gf_next    = 1'b0;
                                wc_next    = hc_reg;
                                h2w_next   = 1'b1;
                                cpn_next   = hc_reg;
                                ret_next   = S_A_CHK;
                                state_next = S_CP_RD;
                            end
                            else
                            begin
                                state_next = S_A_CHK;
                            end
                        end
                        CMD_FREE:
                        begin
                            // A region reaching past the address space is cut at its end.
                            if (sum > LIMIT)
                            begin
                                sz_next = SIZE_W'(LIMIT - {2'b00, region_address});
                            end
                            else
                            begin
                                sz_next = {1'b0, region_size};
                            end
                            if (region_size == '0)
                            begin
                                status_next = ST_FREED;
                                gf_next     = 1'b0;
                                wc_next     = hc_reg;
                                h2w_next    = 1'b1;
                                cpn_next    = hc_reg;
                                ret_next    = S_OUT;
                                state_next  = S_CP_RD;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = S_P_RD;
                            end
                        end
                        CMD_RESET:
                        begin
                            state_next = S_RST;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CP_RD:
            begin
                if (i_reg < cpn_reg)
                begin
                    state_next = S_CP_WR;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ret_reg;
                end
            end
            S_CP_WR:
            begin
                if (h2w_reg)
                begin
                    w_we    = 1'b1;
                    w_waddr = i_reg[IDX_W-1:0];
                    w_wdata = h_rdata;
                end
                else
                begin
                    h_we    = 1'b1;
                    h_waddr = i_reg[IDX_W-1:0];
                    h_wdata = w_rdata;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_CP_RD;
            end
            S_A_CHK:
            begin
                if (gf_reg)
                begin
                    status_next = ST_SKIPPED;
                    if (last_reg)
                    begin
                        gf_next = 1'b0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                state_next = (i_reg < wc_reg) ? S_A_EX : S_A_DEC;
            end
            S_A_EX:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_A_RD;
                if (w_rdata.size >= sz_reg)
                begin
                    if (!cfg.fit_policy)
                    begin
                        found_next = 1'b1;
                        pick_next  = i_reg;
                        pe_next    = w_rdata;
                        state_next = S_A_DEC;
                    end
                    else if (!found_reg || diff < best_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = i_reg;
                        pe_next    = w_rdata;
                        best_next  = diff;
                    end
                end
            end
            S_A_DEC:
            begin
                if (!found_reg)
                begin
                    status_next = ST_NO_FIT;
                    gf_next     = !last_reg;
                    wc_next     = hc_reg;
                    h2w_next    = 1'b1;
                    cpn_next    = hc_reg;
                    ret_next    = S_OUT;
                    i_next      = '0;
                    state_next  = S_CP_RD;
                end
                else
                begin
                    base_next = pe_reg.start;
                    if (pe_reg.size != sz_reg)
                    begin
                        w_we          = 1'b1;
                        w_waddr       = pick_reg[IDX_W-1:0];
                        w_wdata.start = pe_reg.start + sz_reg[ADDR_BITS-1:0];
                        w_wdata.size  = pe_reg.size - sz_reg;
                        state_next    = S_A_FIN;
                    end
                    else
                    begin
                        i_next     = pick_reg;
                        state_next = S_SH_RD;
                    end
                end
            end
            S_SH_RD:
            begin
                rd_addr = IDX_W'(i_reg + 1'b1);
                if (i_reg + 1'b1 < wc_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    wc_next    = wc_reg - 1'b1;
                    state_next = S_A_FIN;
                end
            end
            S_SH_WR:
            begin
                w_we       = 1'b1;
                w_waddr    = i_reg[IDX_W-1:0];
                w_wdata    = w_rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_A_FIN:
            begin
                status_next = ST_PLACED;
                if (last_reg)
                begin
                    comm_next  = 1'b1;
                    hc_next    = wc_reg;
                    h2w_next   = 1'b0;
                    cpn_next   = wc_reg;
                    ret_next   = S_OUT;
                    i_next     = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_P_RD:
            begin
                if (i_reg < hc_reg)
                begin
                    state_next = S_P_EX;
                end
                else
                begin
                    i_next     = '0;
                    ins_next   = 1'b0;
                    have_next  = 1'b0;
                    n_next     = '0;
                    ovf_next   = 1'b0;
                    state_next = S_M_RD;
                end
            end
            S_P_EX:
            begin
                if (h_rdata.start <= addr_reg)
                begin
                    pos_next = i_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_P_RD;
            end
            S_M_RD:
            begin
                // The new hole enters the stream just before old entry pos.
                if (!ins_reg && i_reg == pos_reg)
                begin
                    e.start  = addr_reg;
                    e.size   = sz_reg;
                    mrg      = 1'b1;
                    ins_next = 1'b1;
                end
                else if (i_reg < hc_reg)
                begin
                    state_next = S_M_EX;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_M_END;
                end
            end
            S_M_EX:
            begin
                e          = h_rdata;
                mrg        = 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = S_M_RD;
            end
            S_M_END:
            begin
                gf_next = 1'b0;
                i_next  = '0;
                ret_next = S_OUT;
                state_next = S_CP_RD;
                if (ovf_reg)
                begin
                    status_next = ST_FULL;
                    wc_next     = hc_reg;
                    h2w_next    = 1'b1;
                    cpn_next    = hc_reg;
                end
                else
                begin
                    status_next = ST_FREED;
                    hc_next     = n_reg;
                    wc_next     = n_reg;
                    h2w_next    = 1'b0;
                    cpn_next    = n_reg;
                end
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Streaming merge: the pending hole absorbs an exactly adjacent successor.
        cend = {1'b0, cur_reg.start} + cur_reg.size;
        if (mrg)
        begin
            if (!have_reg)
            begin
                cur_next  = e;
                have_next = 1'b1;
            end
            else if (cend == {1'b0, e.start})
            begin
                cur_next.size = cur_reg.size + e.size;
            end
            else
            begin
                emit     = 1'b1;
                cur_next = e;
            end
        end
        if (emit)
        begin
            if (n_reg < CNT_W'(MAX_HOLES))
            begin
                w_we    = 1'b1;
                w_waddr = n_reg[IDX_W-1:0];
                w_wdata = cur_reg;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            n_next = n_reg + 1'b1;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign seg_base  = base_reg;
    assign status    = status_reg;
    assign committed = comm_reg;

endmodule
`default_nettype wire

// File: tb/sv/hlsa_checker.sv
`timescale 1ns / 1ps
module hlsa_checker
    import hlsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic        group_first,
    input  wire logic        group_last,
    input  wire logic [15:0] region_address,
    input  wire logic [15:0] region_size,
    input  wire logic        done,
    input  wire logic [15:0] seg_base,
    input  wire logic [2:0]  status,
    input  wire logic        committed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);

    typedef struct {
        logic [15:0] base;
        logic [2:0]  stat;
        logic        commit;
    } outcome_t;

    typedef struct {
        longint unsigned start;
        longint unsigned size;
    } span_t;

    span_t           holes[MAX_HOLES];
    span_t           scratch[MAX_HOLES];
    int unsigned     n_holes;
    int unsigned     n_scratch;
    bit              group_dead;
    longint unsigned layout_size;
    bit              best_fit;
    outcome_t        outcome_queue[$];

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void scratch_from_holes();
        scratch = holes;
        n_scratch = n_holes;
    endfunction

    function automatic void relayout();
        for (int i = 0; i < MAX_HOLES; i++)
            holes[i] = '{0, 0};
        holes[0] = '{0, layout_size};
        n_holes = 1;
        scratch_from_holes();
        group_dead = 0;
    endfunction

    function automatic outcome_t place_segment(input bit first, input bit last,
                                               input longint unsigned sz);
        outcome_t o;
        int unsigned pick;
        longint unsigned best;
        o = '{0, ST_PLACED, 0};
        pick = n_scratch;
        best = 0;
        if (first) begin
            scratch_from_holes();
            group_dead = 0;
        end
        if (group_dead) begin
            o.stat = ST_SKIPPED;
            if (last)
                group_dead = 0;
            return o;
        end
        for (int unsigned i = 0; i < n_scratch; i++) begin
            if (scratch[i].size >= sz) begin
                if (!best_fit) begin
                    pick = i;
                    break;
                end
                if (pick == n_scratch || scratch[i].size - sz < best) begin
                    best = scratch[i].size - sz;
                    pick = i;
                end
            end
        end
        if (pick >= n_scratch) begin
            o.stat = ST_NO_FIT;
            scratch_from_holes();
            group_dead = !last;
            return o;
        end
        o.base = scratch[pick].start[15:0];
        scratch[pick].start += sz;
        scratch[pick].size -= sz;
        if (scratch[pick].size == 0) begin
            for (int unsigned i = pick; i + 1 < n_scratch; i++)
                scratch[i] = scratch[i + 1];
            n_scratch--;
            scratch[n_scratch] = '{0, 0};
        end
        if (last) begin
            holes = scratch;
            n_holes = n_scratch;
            o.commit = 1;
        end
        return o;
    endfunction

    function automatic logic [2:0] release_region(input longint unsigned addr,
                                                  input longint unsigned sz);
        span_t merged[$];
        span_t fresh;
        int unsigned pos;
        pos = 0;
        if (addr + sz > 65536)
            sz = 65536 - addr;
        fresh.start = addr;
        fresh.size = sz;
        if (sz != 0) begin
            for (int unsigned i = 0; i < n_holes; i++)
                if (holes[i].start <= addr)
                    pos = i + 1;
            for (int unsigned i = 0; i < n_holes; i++) begin
                if (i == pos)
                    merged.insert(merged.size(), fresh);
                merged.insert(merged.size(), holes[i]);
            end
            if (pos >= merged.size())
                merged.insert(merged.size(), fresh);
            for (int i = 0; i + 1 < merged.size(); ) begin
                if (merged[i].start + merged[i].size == merged[i + 1].start) begin
                    merged[i].size += merged[i + 1].size;
                    merged.delete(i + 1);
                end else begin
                    i++;
                end
            end
            if (merged.size() > MAX_HOLES) begin
                scratch_from_holes();
                group_dead = 0;
                return ST_FULL;
            end
            for (int i = 0; i < MAX_HOLES; i++) begin
                if (i < merged.size())
                    holes[i] = merged[i];
                else
                    holes[i] = '{0, 0};
            end
            n_holes = merged.size();
        end
        scratch_from_holes();
        group_dead = 0;
        return ST_FREED;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t o;
        outcome_t w;
        if (!rst_n) begin
            layout_size = TOTAL_RESET;
            best_fit = 0;
            relayout();
            outcome_queue.delete();
            fail_count = 0;
            result_count = 0;
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == REG_TOTAL_ADDR)
                    layout_size = (pwdata[15:0] < TOTAL_MIN) ? TOTAL_MIN : pwdata[15:0];
                else if (paddr == REG_FIT_ADDR)
                    best_fit = pwdata[0];
            end
            if (done) begin
                result_count++;
                if (outcome_queue.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    w = outcome_queue.pop_front();
                    if (seg_base !== w.base)
                        report("seg_base", seg_base, w.base);
                    if (status !== w.stat)
                        report("status", status, w.stat);
                    if (committed !== w.commit)
                        report("committed", committed, w.commit);
                end
            end
            if (start && !busy) begin
                o = '{0, 0, 0};
                case (command)
                    CMD_ALLOC: o = place_segment(group_first, group_last, region_size);
                    CMD_FREE:  o.stat = release_region(region_address, region_size);
                    CMD_RESET:
                    begin
                        relayout();
                        o.stat = ST_RESET;
                    end
                    default: ;
                endcase
                if (command != CMD_NOP)
                    outcome_queue.insert(outcome_queue.size(), o);
            end
            pending_count = outcome_queue.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import hlsa_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [1:0]  command = CMD_ALLOC;
    logic        group_first = 0;
    logic        group_last = 0;
    logic [15:0] region_address = 0;
    logic [15:0] region_size = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    wire         busy;
    wire         done;
    wire [15:0]  seg_base;
    wire [2:0]   status;
    wire         committed;
    wire [31:0]  prdata;
    wire         pready;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_pct;
    int          cycles = 0;
    int          request_count = 0;

    always #10 clk = ~clk;

    hole_list_segment_allocator_top uut (.*);

    hlsa_checker u_checker (.*);

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel = 1;
        pwrite = 1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    // Lets every pending result drain, plus slack for a command three request
    // that may still be in flight.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // Presents one request at a falling edge and holds it until it is taken.
    // busy is stable at the falling edge, so a low busy there means the request
    // is taken at the next rising edge.
    task automatic send(input logic [1:0] cmd, input logic first, input logic last,
                        input logic [15:0] addr, input logic [15:0] sz);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        start = 1;
        command = cmd;
        group_first = first;
        group_last = last;
        region_address = addr;
        region_size = sz;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        start = 0;
        request_count++;
    endtask

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(1, 120));
        if (r < 80)
            return 16'd0;
        if (r < 92)
            return 16'($urandom_range(100, 1200));
        return 16'($urandom);
    endfunction

    task automatic random_group(input int parts);
        for (int k = 0; k < parts; k++)
            send(CMD_ALLOC, k == 0, k == parts - 1, 16'($urandom), pick_size());
    endtask

    task automatic random_free();
        logic [15:0] a;
        a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
        send(CMD_FREE, 1'($urandom_range(1)), 1'($urandom_range(1)), a,
             ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)));
    endtask

    initial begin
        int r;
        idle_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        reg_write(REG_TOTAL_ADDR, 32'd200);
        reg_write(REG_FIT_ADDR, 32'd0);

        // Directed: whole-hole group, split group, failure and skipping.
        send(CMD_RESET, 0, 0, 0, 0);
        send(CMD_ALLOC, 1, 0, 0, 50);
        send(CMD_ALLOC, 0, 0, 0, 0);
        send(CMD_ALLOC, 0, 1, 0, 150);
        send(CMD_ALLOC, 1, 1, 0, 1);
        send(CMD_FREE, 0, 0, 100, 20);
        send(CMD_FREE, 0, 0, 140, 10);
        send(CMD_FREE, 0, 0, 120, 20);
        send(CMD_FREE, 0, 0, 130, 40);
        send(CMD_FREE, 0, 0, 0, 0);
        send(CMD_ALLOC, 1, 0, 0, 30);
        send(CMD_ALLOC, 0, 0, 0, 16'hFFFF);
        send(CMD_ALLOC, 0, 0, 0, 5);
        send(CMD_ALLOC, 0, 1, 0, 5);
        send(CMD_ALLOC, 0, 0, 0, 10);
        send(CMD_FREE, 1, 1, 16'hFFF0, 16'hFFFF);
        send(CMD_FREE, 0, 0, 16'hFFFF, 1);
        send(CMD_NOP, 1, 1, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 18; k++)
            send(CMD_FREE, 0, 0, 16'(300 + 4 * k), 2);
        send(CMD_RESET, 1, 1, 16'hFFFF, 16'hFFFF);
        drain();
        reg_write(REG_FIT_ADDR, 32'd1);
        reg_write(REG_TOTAL_ADDR, 32'd3);
        send(CMD_RESET, 0, 0, 0, 0);
        send(CMD_FREE, 0, 0, 40, 10);
        send(CMD_FREE, 0, 0, 20, 3);
        send(CMD_ALLOC, 1, 1, 0, 3);

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 45;
                2: idle_pct = 20;
                default: idle_pct = 45;
            endcase
            reg_write(REG_FIT_ADDR, 32'(phase % 2));
            case (phase % 3)
                0: reg_write(REG_TOTAL_ADDR, 32'hFFFF);
                1: reg_write(REG_TOTAL_ADDR, 32'd10);
                default: reg_write(REG_TOTAL_ADDR, 32'($urandom_range(100, 3000)));
            endcase
            send(CMD_RESET, 0, 0, 0, 0);
            while (request_count < 80 + 108 * (phase + 1)) begin
                r = $urandom_range(99);
                if (r < 55)
                    random_group($urandom_range(1, 4));
                else if (r < 80)
                    random_free();
                else if (r < 85)
                    send(CMD_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         16'($urandom), 16'($urandom));
                else if (r < 88)
                    send(CMD_NOP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         16'($urandom), 16'($urandom));
                else
                    send(CMD_ALLOC, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         16'($urandom), pick_size());
            end
        end

        while (pending_count != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        $display("Ran %0d requests (%0d results) over groups, frees, resets and both fit modes,",
                 request_count, result_count);
        $display("with idle sender phases and layout sizes from the minimum to the maximum.");
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
